[src/fst_pkg.sv]
package fst_pkg;

    localparam int NPTS = 5;
    localparam int PW   = 15;   // landmark coordinate
    localparam int SW   = 18;   // sum of five coordinates
    localparam int CW   = 19;   // centered coordinate, signed
    localparam int TW   = 21;   // centered template coordinate, signed
    localparam int PRW  = 40;   // lane products, signed
    localparam int LW   = 41;   // lane sums, signed
    localparam int NW   = 44;   // merged sums, signed
    localparam int SUW  = 22;   // template coordinate sums
    localparam int TNW  = 64;   // divider numerators, signed
    localparam int DW   = 51;   // divider denominators
    localparam int QW   = 34;   // quotient bits before rounding
    localparam int OW   = 32;   // result width
    localparam int SH_A = 16;   // fraction shift for a and b
    localparam int SH_T = 12;   // fraction shift for tx and ty

    localparam logic [SUW-1:0] SUM_U = 22'd2801308;
    localparam logic [SUW-1:0] SUM_V = 22'd3595039;

    localparam logic [9:0]  DEN_A_MUL = 10'd625;
    localparam logic [11:0] DEN_T_MUL = 12'd3125;

    localparam logic signed [OW-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OW-1:0] OUT_MIN = 32'sh8000_0000;

    typedef logic signed [TW-1:0] tmpl_t;

    // template points times five minus their sum, in units of 1e-4 px
    localparam tmpl_t TMPL_UC [NPTS] = '{
        -21'sd886578, 21'sd875282, -21'sd48, -21'sd723843, 21'sd735187
    };
    localparam tmpl_t TMPL_VC [NPTS] = '{
        -21'sd1010224, -21'sd1019969, -21'sd8209, 21'sd1023236, 21'sd1015166
    };

    typedef struct packed {
        logic [PW-1:0] point0_x;
        logic [PW-1:0] point0_y;
        logic [PW-1:0] point1_x;
        logic [PW-1:0] point1_y;
        logic [PW-1:0] point2_x;
        logic [PW-1:0] point2_y;
        logic [PW-1:0] point3_x;
        logic [PW-1:0] point3_y;
        logic [PW-1:0] point4_x;
        logic [PW-1:0] point4_y;
    } points_t;

    typedef struct packed {
        logic signed [OW-1:0] scale_cos;
        logic signed [OW-1:0] scale_sin;
        logic signed [OW-1:0] shift_x;
        logic signed [OW-1:0] neg_scale_sin;
        logic signed [OW-1:0] scale_cos_copy;
        logic signed [OW-1:0] shift_y;
        logic                 degenerate;
    } fit_t;

    typedef struct packed {
        logic signed [LW-1:0] d;
        logic signed [LW-1:0] na;
        logic signed [LW-1:0] nb;
    } lane_sum_t;

endpackage

[src/fst_lane.sv]
module fst_lane
    import fst_pkg::*;
#(
    parameter tmpl_t UC = TMPL_UC[0],
    parameter tmpl_t VC = TMPL_VC[0]
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [PW-1:0] px,
    input  logic [PW-1:0] py,
    input  logic [SW-1:0] sx,
    input  logic [SW-1:0] sy,
    output lane_sum_t     sums
);

    logic signed [CW-1:0]  xc_reg, yc_reg;
    logic signed [CW-1:0]  xc_next, yc_next;
    logic signed [PRW-1:0] xe, ye, ue, ve;
    logic signed [PRW-1:0] xx_reg, yy_reg, xu_reg, yv_reg, yu_reg, xv_reg;
    lane_sum_t             sums_reg, sums_next;

    // 5*p - sum, wraps into the signed range it is known to fit
    assign xc_next = signed'(CW'({px, 2'b00}) + CW'(px) - CW'(sx));
    assign yc_next = signed'(CW'({py, 2'b00}) + CW'(py) - CW'(sy));

    assign xe = {{(PRW-CW){xc_reg[CW-1]}}, xc_reg};
    assign ye = {{(PRW-CW){yc_reg[CW-1]}}, yc_reg};
    assign ue = {{(PRW-TW){UC[TW-1]}}, UC};
    assign ve = {{(PRW-TW){VC[TW-1]}}, VC};

    always_comb
    begin
        sums_next.d  = {xx_reg[PRW-1], xx_reg} + {yy_reg[PRW-1], yy_reg};
        sums_next.na = {xu_reg[PRW-1], xu_reg} + {yv_reg[PRW-1], yv_reg};
        sums_next.nb = {yu_reg[PRW-1], yu_reg} - {xv_reg[PRW-1], xv_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_reg   <= xc_next;
            yc_reg   <= yc_next;
            xx_reg   <= xe * xe;
            yy_reg   <= ye * ye;
            xu_reg   <= xe * ue;
            yv_reg   <= ye * ve;
            yu_reg   <= ye * ue;
            xv_reg   <= xe * ve;
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

[src/fst_div.sv]
module fst_div
    import fst_pkg::*;
#(
    parameter int SHIFT = SH_A
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [TNW-1:0] num,
    input  logic [DW-1:0]         den,
    input  logic                  zero,
    output logic signed [OW-1:0]  res,
    output logic                  res_zero
);

    localparam int NXW = TNW + SHIFT + 1;
    localparam int RW  = (NXW > DW + QW) ? NXW : DW + QW;

    logic [RW-1:0] r_reg   [0:QW-1];
    logic [DW-1:0] d_reg   [0:QW-1];
    logic [QW-1:0] q_reg   [0:QW];
    logic          neg_reg [0:QW];
    logic          zero_reg[0:QW];
    logic          ovf_reg [1:QW];
    logic [TNW-1:0] mag;
    logic [QW:0]    m_full;
    logic [QW-1:0]  m;
    logic           big;
    logic signed [OW-1:0] res_reg, res_next;
    logic                 res_zero_reg;

    assign mag = num[TNW-1] ? unsigned'(-num) : unsigned'(num);

    // dividend is doubled so that rounding needs one more quotient bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= RW'({mag, {(SHIFT+1){1'b0}}});
            d_reg[0]    <= den;
            q_reg[0]    <= '0;
            neg_reg[0]  <= num[TNW-1];
            zero_reg[0] <= zero;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int BIT = QW - k;
        logic [RW-1:0] dsh;
        logic [RW:0]   diff;

        assign dsh  = RW'(d_reg[k-1]) << BIT;
        assign diff = {1'b0, r_reg[k-1]} - {1'b0, dsh};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]    <= q_reg[k-1] | (QW'(!diff[RW]) << BIT);
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end

        if (k < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k] <= diff[RW] ? r_reg[k-1] : diff[RW-1:0];
                    d_reg[k] <= d_reg[k-1];
                end
            end
        end

        if (k == 1)
        begin : g_ovf
            // quotient would not fit in the quotient bits
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ovf_reg[k] <= r_reg[0] >= (RW'(d_reg[0]) << QW);
                end
            end
        end
        else
        begin : g_ovf_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end
        end
    end

    // round half away from zero on the magnitude, then saturate
    assign m_full = {1'b0, q_reg[QW]} + (QW+1)'(1);
    assign m      = m_full[QW:1];
    assign big    = ovf_reg[QW] || (|m[QW-1:OW-1]);

    always_comb
    begin
        if (zero_reg[QW])
        begin
            res_next = '0;
        end
        else if (neg_reg[QW])
        begin
            res_next = big ? OUT_MIN : signed'(-m[OW-1:0]);
        end
        else
        begin
            res_next = big ? OUT_MAX : signed'(m[OW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg      <= res_next;
            res_zero_reg <= zero_reg[QW];
        end
    end

    assign res      = res_reg;
    assign res_zero = res_zero_reg;

endmodule

[src/face_similarity_transform_fit_core.sv]
// five-point similarity fit, one landmark set in and one 2x3 matrix out per item
// five point lanes feed four pipelined dividers
// throughput: one item per cycle while point_ready is high
// two-entry output register and skid stage keep point_ready high while one result waits
// reset (rst_n low, asynchronous) empties the pipeline and the output stage
module face_similarity_transform_fit_core
    import fst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    point_valid,
    output logic    point_ready,
    input  points_t points,
    output logic    fit_valid,
    input  logic    fit_ready,
    output fit_t    fit
);

    localparam int LAT = 7 + QW + 2;

    logic en, deliver, take;
    logic v_reg [0:LAT-1];

    logic [PW-1:0] px [NPTS];
    logic [PW-1:0] py [NPTS];
    logic [SW-1:0] sx_next, sy_next;

    logic [PW-1:0] px_reg [NPTS];
    logic [PW-1:0] py_reg [NPTS];
    logic [SW-1:0] sx_reg [0:4];
    logic [SW-1:0] sy_reg [0:4];

    lane_sum_t sums [NPTS];

    logic signed [NW-1:0] dsum_next, na_next, nb_next;
    logic signed [NW-1:0] dsum_e_reg, na_e_reg, nb_e_reg;
    logic                 dgn_e_reg;

    logic signed [TNW-1:0] sxe, sye, dse, nae, nbe, sue, sve;
    logic signed [TNW-1:0] pu_reg, pv_reg, nasx_reg, nbsy_reg, nbsx_reg, nasy_reg;
    logic signed [NW-1:0]  dsum_f_reg, na_f_reg, nb_f_reg;
    logic                  dgn_f_reg;

    logic [DW-1:0]         dsu;
    logic signed [TNW-1:0] tnx_reg, tny_reg, na_g_reg, nb_g_reg;
    logic [DW-1:0]         den_a_reg, den_t_reg;
    logic                  dgn_g_reg;

    logic signed [OW-1:0] a_res, b_res, tx_res, ty_res;
    logic                 a_zero, b_zero, tx_zero, ty_zero;

    fit_t res_next, fit_reg, skid_reg;
    logic fit_valid_reg, skid_valid_reg;

    assign en          = !skid_valid_reg;
    assign point_ready = en;

    assign px[0] = points.point0_x;
    assign py[0] = points.point0_y;
    assign px[1] = points.point1_x;
    assign py[1] = points.point1_y;
    assign px[2] = points.point2_x;
    assign py[2] = points.point2_y;
    assign px[3] = points.point3_x;
    assign py[3] = points.point3_y;
    assign px[4] = points.point4_x;
    assign py[4] = points.point4_y;

    always_comb
    begin
        sx_next = '0;
        sy_next = '0;
        for (int i = 0; i < NPTS; i++)
        begin
            sx_next = sx_next + SW'(px[i]);
            sy_next = sy_next + SW'(py[i]);
        end
    end

    // item valid travels alongside the data through every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= point_valid;
            for (int i = 1; i < LAT; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NPTS; i++)
            begin
                px_reg[i] <= px[i];
                py_reg[i] <= py[i];
            end
            sx_reg[0] <= sx_next;
            sy_reg[0] <= sy_next;
            for (int i = 1; i < 5; i++)
            begin
                sx_reg[i] <= sx_reg[i-1];
                sy_reg[i] <= sy_reg[i-1];
            end
        end
    end

    for (genvar i = 0; i < NPTS; i++)
    begin : g_lane
        fst_lane #(
            .UC (TMPL_UC[i]),
            .VC (TMPL_VC[i])
        ) u_lane (
            .clk  (clk),
            .en   (en),
            .px   (px_reg[i]),
            .py   (py_reg[i]),
            .sx   (sx_reg[0]),
            .sy   (sy_reg[0]),
            .sums (sums[i])
        );
    end

    // merge the lanes
    always_comb
    begin
        dsum_next = '0;
        na_next   = '0;
        nb_next   = '0;
        for (int i = 0; i < NPTS; i++)
        begin
            dsum_next = dsum_next + {{(NW-LW){sums[i].d[LW-1]}}, sums[i].d};
            na_next   = na_next + {{(NW-LW){sums[i].na[LW-1]}}, sums[i].na};
            nb_next   = nb_next + {{(NW-LW){sums[i].nb[LW-1]}}, sums[i].nb};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsum_e_reg <= dsum_next;
            na_e_reg   <= na_next;
            nb_e_reg   <= nb_next;
            dgn_e_reg  <= (dsum_next == '0);
        end
    end

    assign sxe = signed'(TNW'(sx_reg[4]));
    assign sye = signed'(TNW'(sy_reg[4]));
    assign dse = {{(TNW-NW){dsum_e_reg[NW-1]}}, dsum_e_reg};
    assign nae = {{(TNW-NW){na_e_reg[NW-1]}}, na_e_reg};
    assign nbe = {{(TNW-NW){nb_e_reg[NW-1]}}, nb_e_reg};
    assign sue = signed'(TNW'(SUM_U));
    assign sve = signed'(TNW'(SUM_V));

    // translation numerators: mean terms scaled by D
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg     <= sue * dse;
            pv_reg     <= sve * dse;
            nasx_reg   <= nae * sxe;
            nbsy_reg   <= nbe * sye;
            nbsx_reg   <= nbe * sxe;
            nasy_reg   <= nae * sye;
            dsum_f_reg <= dsum_e_reg;
            na_f_reg   <= na_e_reg;
            nb_f_reg   <= nb_e_reg;
            dgn_f_reg  <= dgn_e_reg;
        end
    end

    assign dsu = DW'(unsigned'(dsum_f_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tnx_reg   <= pu_reg - nasx_reg - nbsy_reg;
            tny_reg   <= pv_reg + nbsx_reg - nasy_reg;
            na_g_reg  <= {{(TNW-NW){na_f_reg[NW-1]}}, na_f_reg};
            nb_g_reg  <= {{(TNW-NW){nb_f_reg[NW-1]}}, nb_f_reg};
            den_a_reg <= dsu * DW'(DEN_A_MUL);
            den_t_reg <= dsu * DW'(DEN_T_MUL);
            dgn_g_reg <= dgn_f_reg;
        end
    end

    fst_div #(.SHIFT(SH_A)) u_div_a (
        .clk      (clk),
        .en       (en),
        .num      (na_g_reg),
        .den      (den_a_reg),
        .zero     (dgn_g_reg),
        .res      (a_res),
        .res_zero (a_zero)
    );

    fst_div #(.SHIFT(SH_A)) u_div_b (
        .clk      (clk),
        .en       (en),
        .num      (nb_g_reg),
        .den      (den_a_reg),
        .zero     (dgn_g_reg),
        .res      (b_res),
        .res_zero (b_zero)
    );

    fst_div #(.SHIFT(SH_T)) u_div_tx (
        .clk      (clk),
        .en       (en),
        .num      (tnx_reg),
        .den      (den_t_reg),
        .zero     (dgn_g_reg),
        .res      (tx_res),
        .res_zero (tx_zero)
    );

    fst_div #(.SHIFT(SH_T)) u_div_ty (
        .clk      (clk),
        .en       (en),
        .num      (tny_reg),
        .den      (den_t_reg),
        .zero     (dgn_g_reg),
        .res      (ty_res),
        .res_zero (ty_zero)
    );

    always_comb
    begin
        res_next.scale_cos      = a_res;
        res_next.scale_sin      = b_res;
        res_next.shift_x        = tx_res;
        res_next.neg_scale_sin  = (b_res == OUT_MIN) ? OUT_MAX : -b_res;
        res_next.scale_cos_copy = a_res;
        res_next.shift_y        = ty_res;
        res_next.degenerate     = a_zero & b_zero & tx_zero & ty_zero;
    end

    assign deliver = en && v_reg[LAT-1];
    assign take    = fit_valid_reg && fit_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (deliver)
        begin
            if (!fit_valid_reg || take)
            begin
                fit_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            fit_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                fit_reg <= skid_reg;
            end
        end
        else if (deliver)
        begin
            if (!fit_valid_reg || take)
            begin
                fit_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
    end

    assign fit_valid = fit_valid_reg;
    assign fit       = fit_reg;

endmodule
